// ----- sv/sil_pkg.sv -----
package sil_pkg;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_BADPOS = 2'd2
    } t_status;

    // Input word
    typedef struct packed {
        t_func       func;
        logic [15:0] key;
        logic [15:0] payload;
        logic [3:0]  position;
    } t_cmd;

    // Result word
    typedef struct packed {
        t_status     status;
        logic [15:0] entry_key;
        logic [15:0] entry_payload;
        logic [4:0]  count;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    insert_en;
        logic    remove_en;
        logic    res_load;
        logic    entry_sel;
        t_status res_status;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        t_func func;
        logic  full;
        logic  pos_ok;
    } t_dp_stat;

endpackage

// ----- sv/sil_ctrl.sv -----
module sil_ctrl import sil_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl,
    output logic     o_busy,
    output logic     o_strobe
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_strobe;

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = start ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state == ST_EXEC);
            r_strobe <= (r_state == ST_EXEC);
        end
    end

    // Decode the held word against list status
    always_comb begin
        o_ctl            = '0;
        o_ctl.res_status = STATUS_DONE;
        o_ctl.capture    = (r_state == ST_IDLE) && start;
        if (r_state == ST_EXEC) begin
            o_ctl.res_load = 1'b1;
            unique case (i_stat.func)
                FUNC_INSERT: begin
                    if (i_stat.full) begin
                        o_ctl.res_status = STATUS_FULL;
                    end else begin
                        o_ctl.insert_en = 1'b1;
                    end
                end
                FUNC_REMOVE: begin
                    if (i_stat.pos_ok) begin
                        o_ctl.remove_en = 1'b1;
                        o_ctl.entry_sel = 1'b1;
                    end else begin
                        o_ctl.res_status = STATUS_BADPOS;
                    end
                end
                FUNC_READ: begin
                    if (i_stat.pos_ok) begin
                        o_ctl.entry_sel = 1'b1;
                    end else begin
                        o_ctl.res_status = STATUS_BADPOS;
                    end
                end
                default: begin
                    o_ctl.res_status = STATUS_DONE;
                end
            endcase
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

// ----- sv/sil_datapath.sv -----
module sil_datapath import sil_pkg::*; #(
    parameter int CAPACITY     = 16,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  t_dp_ctl  i_ctl,
    output t_dp_stat o_stat,
    output t_result  o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > 4) ? CW : 4;

    t_cmd                    r_cmd;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [KEY_BITS-1:0]     r_keys [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_pays [CAPACITY];
    logic [CAPACITY-1:0]     w_le;
    logic [KEY_BITS-1:0]     w_new_key;
    logic [PAYLOAD_BITS-1:0] w_new_pay;
    logic [PW-1:0]           w_pos;
    logic [IW-1:0]           w_idx;
    t_result                 r_result;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
        end
    end

    assign w_new_key = KEY_BITS'(r_cmd.key);
    assign w_new_pay = PAYLOAD_BITS'(r_cmd.payload);
    assign w_pos     = PW'(r_cmd.position);
    assign w_idx     = w_pos[IW-1:0];

    assign o_stat.func   = r_cmd.func;
    assign o_stat.full   = (r_count == CW'(CAPACITY));
    assign o_stat.pos_ok = (w_pos < PW'(r_count));

    // Row of compare-and-shift cells; entries below count form a sorted prefix
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;

        logic                    w_first;
        logic [KEY_BITS-1:0]     n_key;
        logic [PAYLOAD_BITS-1:0] n_pay;

        assign w_le[g]  = (CW'(g) < r_count) && (r_keys[g] <= w_new_key);
        assign w_first  = (g == 0) ? 1'b1 : w_le[PREV];

        always_comb begin
            n_key = r_keys[g];
            n_pay = r_pays[g];
            if (i_ctl.insert_en && !w_le[g]) begin
                if (w_first) begin
                    n_key = w_new_key;
                    n_pay = w_new_pay;
                end else begin
                    n_key = r_keys[PREV];
                    n_pay = r_pays[PREV];
                end
            end else if (i_ctl.remove_en && (PW'(g) >= w_pos)) begin
                n_key = r_keys[NEXT];
                n_pay = r_pays[NEXT];
            end
        end

        always_ff @(posedge i_clk) begin
            r_keys[g] <= n_key;
            r_pays[g] <= n_pay;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.insert_en) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.remove_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_result.status <= i_ctl.res_status;
            r_result.count  <= 5'(n_count);
            if (i_ctl.entry_sel) begin
                r_result.entry_key     <= 16'(r_keys[w_idx]);
                r_result.entry_payload <= 16'(r_pays[w_idx]);
            end else begin
                r_result.entry_key     <= '0;
                r_result.entry_payload <= '0;
            end
        end
    end

    assign o_result = r_result;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.insert_en |-> (r_count < CW'(CAPACITY)))
        else $error("insert into a full list");

    a_remove_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.remove_en |-> (w_pos < PW'(r_count)))
        else $error("remove at a position outside the list");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.insert_en |=> (r_count == $past(r_count) + 1'b1))
        else $error("count did not advance on insert");

endmodule

// ----- sv/sorted_insert_list.sv -----
// Sorted insert list: a fixed-capacity list kept in ascending unsigned key order.
// Input channel: drive i_cmd and raise start; the word is taken at the rising
// edge where start is high and busy is low. func selects insert (stable: the new
// entry lands after every entry with a key less than or equal to its own),
// remove at position (the gap closes), or read at position. Unused func code 3
// does nothing and reports done.
// Result channel: o_strobe is high for exactly one cycle with o_result valid;
// the receiver must take it then, it cannot stall the block.
// Order: the accepting edge enters the execute state; the edge ending it loads
// the result and raises the strobe. busy is high for the one execute cycle, and
// no new word is taken until idle; start may be held high during the strobe
// cycle. The cell row shifts all slots at once.
// Status reports list full on insert, or a position not below the count; the
// count after the operation rides on every result.
// Reset (synchronous, active low) empties the list and idles the controller;
// slot contents are not cleared and are never read before being written.
module sorted_insert_list import sil_pkg::*; #(
    parameter int CAPACITY     = 16,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    // Sequence capture and execute, decode status into shift commands
    sil_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_stat   (w_stat),
        .o_ctl    (w_ctl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // Hold the slot row, count and result register
    sil_datapath #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (w_ctl),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule
